FILE: rtl/core/mfcv_pkg.sv
// Package for the multi-frame class vote block.
// Holds the payload structs and fixed field widths; no dependencies.
package mfcv_pkg;

  localparam int unsigned CONF_W = 16;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SUM_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_NUM_POSITIONS = 8;
  localparam int unsigned DEF_NUM_CLASSES = 16;
  localparam int unsigned DEF_MAX_VOTES = 255;

  localparam logic FUNC_VOTE = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOTE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AVG_CONF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITIONS_IN_USE = 2'd2;

  typedef struct packed {
    logic                func;
    logic [2:0]          in_position;
    logic [3:0]          in_class;
    logic [CONF_W-1:0]   in_confidence;
    logic [COORD_W-1:0]  in_center_x;
    logic [COORD_W-1:0]  in_center_y;
  } in_t;

  typedef struct packed {
    logic [2:0]          out_position;
    logic                found;
    logic [3:0]          out_class;
    logic [CONF_W-1:0]   mean_conf;
    logic [7:0]          vote_count;
    logic [COORD_W-1:0]  out_center_x;
    logic [COORD_W-1:0]  out_center_y;
    logic                last_result;
  } out_t;

endpackage

FILE: rtl/core/mfcv_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by multi_frame_class_vote for the average confidence.
module mfcv_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [VW-1:0]    div_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [VW:0]      shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    fits = shifted >= {1'b0, div_q};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT_W'(DW);
    end else if (cnt_q != '0) begin
      rem_d = fits ? VW'(shifted - {1'b0, div_q}) : VW'(shifted);
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/core/multi_frame_class_vote.sv
// Multi-frame class vote: a table of counts, confidence sums and best centres.
// A vote beat runs through accept, table read and write back. A resolve beat takes the
// accept step, then per reported position a table walk over all classes, a division
// (skipped when the position has no votes) and an output beat that holds while stalled,
// then a clearing pass over all NUM_POSITIONS*NUM_CLASSES entries; input stalls throughout.
// After reset the same clearing pass runs before the first beat is taken. Uses mfcv_pkg, mfcv_div.
module multi_frame_class_vote #(
  parameter int unsigned NUM_POSITIONS = mfcv_pkg::DEF_NUM_POSITIONS,
  parameter int unsigned NUM_CLASSES = mfcv_pkg::DEF_NUM_CLASSES,
  parameter int unsigned MAX_VOTES = mfcv_pkg::DEF_MAX_VOTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mfcv_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mfcv_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mfcv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mfcv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mfcv_pkg::*;

  localparam int unsigned ENTRIES = NUM_POSITIONS * NUM_CLASSES;
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(MAX_VOTES + 1);
  localparam int unsigned CLW = $clog2(NUM_CLASSES);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;
  localparam int unsigned MAXP = (NUM_POSITIONS < 8) ? NUM_POSITIONS : 8;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VRD   = 4'd2;
  localparam logic [3:0] S_VWR   = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RCMP  = 4'd5;
  localparam logic [3:0] S_DST   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  typedef struct packed {
    logic [CW-1:0]      cnt;
    logic [SUM_W-1:0]   sum;
    logic [CONF_W-1:0]  bconf;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_q, wr_entry;
  logic   we;

  logic [3:0]      state_q, state_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [2:0]      pos_q, pos_d, last_pos_q, last_pos_d;
  logic [CLW-1:0]  cls_q, cls_d;
  logic            any_q, any_d;
  logic [CLW-1:0]  best_q, best_d;
  logic [CW-1:0]   bcnt_q, bcnt_d;
  logic [SUM_W-1:0] bsum_q, bsum_d;
  logic [COORD_W-1:0] bcx_q, bcx_d, bcy_q, bcy_d;
  in_t             in_q;
  out_t            out_q, out_d;

  logic [7:0]        min_cnt_q;
  logic [CONF_W-1:0] min_avg_q;
  logic [3:0]        piu_q;

  logic            div_start, div_done;
  logic [SUM_W-1:0] quot;
  logic [CONF_W-1:0] avg;
  logic            ok;
  logic [SUM_W:0]  sum_ext;
  logic [3:0]      n_pos;
  logic            better;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cnt_q <= 8'd3;
      min_avg_q <= 16'd32768;
      piu_q <= 4'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_VOTE_COUNT:   min_cnt_q <= cfg_data_i[7:0];
        REG_MIN_AVG_CONF:     min_avg_q <= cfg_data_i;
        REG_POSITIONS_IN_USE: piu_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Read-modify-write of one entry for a vote; the clearing pass writes zero instead.
  always_comb begin
    wr_entry = rd_q;
    sum_ext = {1'b0, rd_q.sum} + (SUM_W + 1)'(in_q.in_confidence);
    if (rd_q.cnt == '0 || in_q.in_confidence > rd_q.bconf) begin
      wr_entry.bconf = in_q.in_confidence;
      wr_entry.cx = in_q.in_center_x;
      wr_entry.cy = in_q.in_center_y;
    end
    if (CMPW'(rd_q.cnt) < CMPW'(MAX_VOTES)) begin
      wr_entry.cnt = rd_q.cnt + 1'b1;
      wr_entry.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
    if (state_q == S_CLEAR) begin
      wr_entry = '0;
    end
  end

  assign we = (state_q == S_CLEAR) || (state_q == S_VWR);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q] <= wr_entry;
    end
    rd_q <= mem[addr_q];
  end

  mfcv_div #(.DW(SUM_W), .VW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (bsum_q),
    .divisor_i  (bcnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign avg = (quot > SUM_W'(16'hFFFF)) ? 16'hFFFF : quot[CONF_W-1:0];
  assign ok = (CMPW'(bcnt_q) >= CMPW'(min_cnt_q)) && (avg >= min_avg_q);
  assign div_start = (state_q == S_DST);

  always_comb begin
    if (piu_q == 4'd0) begin
      n_pos = 4'd1;
    end else if (piu_q > 4'(MAXP)) begin
      n_pos = 4'(MAXP);
    end else begin
      n_pos = piu_q;
    end
  end

  assign better = (rd_q.cnt != '0) &&
                  (!any_q || rd_q.cnt > bcnt_q || (rd_q.cnt == bcnt_q && rd_q.sum > bsum_q));

  always_comb begin
    state_d = state_q;
    addr_d = addr_q;
    pos_d = pos_q;
    last_pos_d = last_pos_q;
    cls_d = cls_q;
    any_d = any_q;
    best_d = best_q;
    bcnt_d = bcnt_q;
    bsum_d = bsum_q;
    bcx_d = bcx_q;
    bcy_d = bcy_q;
    out_d = out_q;
    unique case (state_q)
      S_CLEAR: begin
        if (addr_q == AW'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_RESOLVE) begin
            addr_d = '0;
            pos_d = '0;
            cls_d = '0;
            any_d = 1'b0;
            bcnt_d = '0;
            bsum_d = '0;
            last_pos_d = 3'(n_pos - 4'd1);
            state_d = S_RRD;
          end else if (5'(in_data_i.in_position) < 5'(NUM_POSITIONS) &&
                       7'(in_data_i.in_class) < 7'(NUM_CLASSES)) begin
            addr_d = AW'(AW'(in_data_i.in_position) * AW'(NUM_CLASSES)
                         + AW'(in_data_i.in_class));
            state_d = S_VRD;
          end
        end
      end
      S_VRD: state_d = S_VWR;
      S_VWR: state_d = S_IDLE;
      S_RRD: state_d = S_RCMP;
      S_RCMP: begin
        if (better) begin
          any_d = 1'b1;
          best_d = cls_q;
          bcnt_d = rd_q.cnt;
          bsum_d = rd_q.sum;
          bcx_d = rd_q.cx;
          bcy_d = rd_q.cy;
        end
        if (cls_q == CLW'(NUM_CLASSES - 1)) begin
          state_d = S_DST;
        end else begin
          cls_d = cls_q + 1'b1;
          addr_d = addr_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_DST: begin
        if (any_q) begin
          state_d = S_DIV;
        end else begin
          out_d = '0;
          out_d.out_position = pos_q;
          out_d.last_result = (pos_q == last_pos_q);
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_d.out_position = pos_q;
          out_d.found = ok;
          out_d.out_class = ok ? 4'(best_q) : 4'd0;
          out_d.mean_conf = avg;
          out_d.vote_count = 8'(bcnt_q);
          out_d.out_center_x = ok ? bcx_q : '0;
          out_d.out_center_y = ok ? bcy_q : '0;
          out_d.last_result = (pos_q == last_pos_q);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (pos_q == last_pos_q) begin
            addr_d = '0;
            state_d = S_CLEAR;
          end else begin
            pos_d = pos_q + 1'b1;
            cls_d = '0;
            any_d = 1'b0;
            bcnt_d = '0;
            bsum_d = '0;
            addr_d = addr_q + 1'b1;
            state_d = S_RRD;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q <= '0;
      pos_q <= '0;
      last_pos_q <= '0;
      cls_q <= '0;
      any_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      pos_q <= pos_d;
      last_pos_q <= last_pos_d;
      cls_q <= cls_d;
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bcnt_q <= bcnt_d;
    bsum_q <= bsum_d;
    bcx_q <= bcx_d;
    bcy_q <= bcy_d;
    out_q <= out_d;
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o = out_q;

`ifndef SYNTH
  // The table is only written by the sweep or by a vote write back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VWR) |-> ($past(state_q) == S_VRD))
    else $error("vote write back without a table read");
  // A finished resolve always runs a full clearing pass before idling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_result && !out_stall_i) |=> (state_q == S_CLEAR))
    else $error("resolve did not start the clearing pass");
  // A result beat never reports a position past the last one in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_position <= last_pos_q))
    else $error("result position beyond positions in use");
  // Found results always carry a nonzero vote count (unless MAX_VOTES exceeds the 8-bit field).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.vote_count != 8'd0 || MAX_VOTES > 255))
    else $error("found result without votes");
`endif

endmodule
